FILE: rtl/ppp_pkg.sv
// shared types, constants and helpers for the perspective point projection block
package ppp_pkg;

   localparam int FRAC_BITS = 16;
   localparam int ROW_W = 50;
   localparam int QDIV_BITS = 32;

   localparam logic [2:0] REG_X0 = 3'd0;
   localparam logic [2:0] REG_X1 = 3'd1;
   localparam logic [2:0] REG_Y0 = 3'd2;
   localparam logic [2:0] REG_Y1 = 3'd3;
   localparam logic [2:0] REG_W0 = 3'd4;
   localparam logic [2:0] REG_W1 = 3'd5;
   localparam logic [2:0] REG_SW = 3'd6;
   localparam logic [2:0] REG_SH = 3'd7;

   typedef struct packed {
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] screen_x;
      logic signed [31:0] screen_y;
      logic signed [31:0] depth;
      logic visible;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] c0;
      logic signed [31:0] c1;
      logic signed [31:0] c2;
      logic signed [31:0] c3;
   } row_type;

   // classified item handed from front to back
   typedef struct packed {
      logic signed [ROW_W-1:0] cx;
      logic signed [ROW_W-1:0] cy;
      logic signed [ROW_W-1:0] cw;
      logic front;
   } clip_type;

   function automatic logic signed [31:0] sat32(input logic signed [ROW_W+16:0] v);
      logic signed [ROW_W+16:0] hi;
      logic signed [ROW_W+16:0] lo;
      hi = (ROW_W+17)'(64'sd2147483647);
      lo = -(ROW_W+17)'(64'sd2147483648);
      if (v > hi) return 32'sh7fffffff;
      else if (v < lo) return 32'sh80000000;
      else return v[31:0];
   endfunction

endpackage

FILE: rtl/perspective_point_projection.sv
// a point passes from the front through the queue to the back before its result appears
// throughput: one point per cycle unless the output stalls, a fully pipelined 32-stage divider sets the back end
// front and back each stall as a whole, the queue between them holds up to four points
// reset: synchronous, clears valid state, matrix rows to zero, screen 1920 by 1080
// config writes are taken at any time, always ready
// top level of the perspective point projection block
module perspective_point_projection import ppp_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  req_type req_data,
   output logic rsp_valid,
   input  logic rsp_ready,
   output rsp_type rsp_data,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [2:0] csr_index,
   input  logic [63:0] csr_data
);
   logic [63:0] regs_ff [6];
   logic [13:0] sw_ff, sh_ff;
   row_type rx, ry, rw;
   logic fv, fr, qv, qr;
   clip_type fd, qd;

   assign csr_ready = 1'b1;
   assign rx = {regs_ff[REG_X0], regs_ff[REG_X1]};
   assign ry = {regs_ff[REG_Y0], regs_ff[REG_Y1]};
   assign rw = {regs_ff[REG_W0], regs_ff[REG_W1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) regs_ff[i] <= '0;
         sw_ff <= 14'd1920;
         sh_ff <= 14'd1080;
      end else if (csr_valid) begin
         case (csr_index)
            REG_SW: sw_ff <= csr_data[13:0];
            REG_SH: sh_ff <= csr_data[13:0];
            default: regs_ff[csr_index] <= csr_data;
         endcase
      end
   end

   ppp_front u_front (
      .clock, .reset,
      .in_valid(req_valid), .in_ready(req_ready), .in_data(req_data),
      .row_x(rx), .row_y(ry), .row_w(rw),
      .out_valid(fv), .out_ready(fr), .out_data(fd)
   );

   ppp_fifo u_fifo (
      .clock, .reset,
      .in_valid(fv), .in_ready(fr), .in_data(fd),
      .out_valid(qv), .out_ready(qr), .out_data(qd)
   );

   ppp_back u_back (
      .clock, .reset,
      .in_valid(qv), .in_ready(qr), .in_data(qd),
      .scr_w(sw_ff), .scr_h(sh_ff),
      .out_valid(rsp_valid), .out_ready(rsp_ready), .out_data(rsp_data)
   );
endmodule

FILE: rtl/ppp_front.sv
// front: row dot products, near test and classification
module ppp_front import ppp_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  req_type in_data,
   input  row_type row_x,
   input  row_type row_y,
   input  row_type row_w,
   output logic out_valid,
   input  logic out_ready,
   output clip_type out_data
);
   // stage 1 products, stage 2 sums and classify
   logic v1_ff, v2_ff;
   logic signed [63:0] p_ff [9];
   logic signed [31:0] k_ff [3];
   clip_type c_ff;
   logic signed [63:0] p_in [9];
   logic signed [ROW_W-1:0] s_in [3];
   logic adv;
   clip_type c_in;

   assign adv = !v2_ff || out_ready;
   assign in_ready = adv;
   assign out_valid = v2_ff;
   assign out_data = c_ff;

   always_comb begin
      p_in[0] = row_x.c0 * in_data.point_x;
      p_in[1] = row_x.c1 * in_data.point_y;
      p_in[2] = row_x.c2 * in_data.point_z;
      p_in[3] = row_y.c0 * in_data.point_x;
      p_in[4] = row_y.c1 * in_data.point_y;
      p_in[5] = row_y.c2 * in_data.point_z;
      p_in[6] = row_w.c0 * in_data.point_x;
      p_in[7] = row_w.c1 * in_data.point_y;
      p_in[8] = row_w.c2 * in_data.point_z;
      for (int r = 0; r < 3; r++) begin
         s_in[r] = ROW_W'(k_ff[r])
            + ROW_W'(p_ff[3*r] >>> FRAC_BITS)
            + ROW_W'(p_ff[3*r+1] >>> FRAC_BITS)
            + ROW_W'(p_ff[3*r+2] >>> FRAC_BITS);
      end
      c_in.cx = s_in[0];
      c_in.cy = s_in[1];
      c_in.cw = s_in[2];
      c_in.front = (s_in[2] > 0)
         && ((ROW_W+7)'(s_in[2]) * (ROW_W+7)'(100) >= (ROW_W+7)'(64'sd1 <<< FRAC_BITS));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
      if (adv) begin
         p_ff <= p_in;
         k_ff[0] <= row_x.c3;
         k_ff[1] <= row_y.c3;
         k_ff[2] <= row_w.c3;
         c_ff <= c_in;
      end
   end
endmodule

FILE: rtl/ppp_fifo.sv
// short queue between front and back
module ppp_fifo import ppp_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  clip_type in_data,
   output logic out_valid,
   input  logic out_ready,
   output clip_type out_data
);
   clip_type mem_ff [4];
   logic [1:0] wp_ff, rp_ff;
   logic [2:0] cnt_ff;
   logic wr, rd;

   assign in_ready = cnt_ff != 3'd4;
   assign out_valid = cnt_ff != 3'd0;
   assign out_data = mem_ff[rp_ff];
   assign wr = in_valid && in_ready;
   assign rd = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (wr) wp_ff <= wp_ff + 2'd1;
         if (rd) rp_ff <= rp_ff + 2'd1;
         cnt_ff <= cnt_ff + 3'(wr) - 3'(rd);
      end
      if (wr) mem_ff[wp_ff] <= in_data;
   end

   a_cnt: assert property (@(posedge clock) disable iff (reset) cnt_ff <= 3'd4)
      else $error("queue count overflow");
endmodule

FILE: rtl/ppp_back.sv
// back: pipelined divider, screen mapping and bounds test
module ppp_back import ppp_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  clip_type in_data,
   input  logic [13:0] scr_w,
   input  logic [13:0] scr_h,
   output logic out_valid,
   input  logic out_ready,
   output rsp_type out_data
);
   // one quotient bit per stage for x and y, magnitude capped at 2^31
   localparam int NS = QDIV_BITS;
   localparam int AW = ROW_W + FRAC_BITS;
   localparam int TW = ROW_W + NS + 1;
   localparam int MAXI = 31 - FRAC_BITS;

   typedef struct packed {
      logic [AW-1:0] rx;
      logic [AW-1:0] ry;
      logic [31:0] qx;
      logic [31:0] qy;
      logic nx, ny, ox, oy;
      logic [ROW_W-1:0] d;
      logic front;
      logic signed [31:0] depth;
   } dv_type;

   logic v_ff [NS+3];
   dv_type st_ff [NS+1];
   dv_type st_in [NS+1];
   logic signed [48:0] mx_ff, my_ff;
   logic signed [47:0] bw_ff, bh_ff;
   logic front_ff, f2_ff;
   logic signed [31:0] dep_ff, dep2_ff;
   rsp_type r_ff;
   logic adv;

   assign adv = !v_ff[NS+2] || out_ready;
   assign in_ready = adv;
   assign out_valid = v_ff[NS+2];
   assign out_data = r_ff;

   always_comb begin
      logic [ROW_W-1:0] ax, ay;
      logic [TW-1:0] tx, ty;
      ax = in_data.cx[ROW_W-1] ? ROW_W'(-in_data.cx) : ROW_W'(in_data.cx);
      ay = in_data.cy[ROW_W-1] ? ROW_W'(-in_data.cy) : ROW_W'(in_data.cy);
      st_in[0].rx = {ax, {FRAC_BITS{1'b0}}};
      st_in[0].ry = {ay, {FRAC_BITS{1'b0}}};
      st_in[0].qx = '0;
      st_in[0].qy = '0;
      st_in[0].nx = in_data.cx[ROW_W-1];
      st_in[0].ny = in_data.cy[ROW_W-1];
      st_in[0].d = in_data.cw;
      st_in[0].front = in_data.front;
      st_in[0].depth = sat32((ROW_W+17)'(in_data.cw));
      // magnitude of integer part too large: saturate
      st_in[0].ox = (ax >> MAXI) >= in_data.cw;
      st_in[0].oy = (ay >> MAXI) >= in_data.cw;
      for (int i = 1; i <= NS; i++) begin
         st_in[i] = st_ff[i-1];
         tx = TW'(st_ff[i-1].rx) - (TW'(st_ff[i-1].d) << (NS - i));
         ty = TW'(st_ff[i-1].ry) - (TW'(st_ff[i-1].d) << (NS - i));
         if (!tx[TW-1]) begin
            st_in[i].rx = tx[AW-1:0];
            st_in[i].qx[NS-i] = 1'b1;
         end
         if (!ty[TW-1]) begin
            st_in[i].ry = ty[AW-1:0];
            st_in[i].qy[NS-i] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NS + 3; i++) v_ff[i] <= 1'b0;
      end else if (adv) begin
         v_ff[0] <= in_valid;
         for (int i = 1; i < NS + 3; i++) v_ff[i] <= v_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      logic signed [32:0] qx, qy;
      logic signed [33:0] ex, ey;
      logic signed [48:0] sx, sy;
      logic signed [47:0] lw, lh;
      if (adv) begin
         for (int i = 0; i <= NS; i++) st_ff[i] <= st_in[i];
         // mapping stage: multiply
         qx = st_ff[NS].ox ? 33'sh080000000 : 33'($signed({1'b0, st_ff[NS].qx}));
         qy = st_ff[NS].oy ? 33'sh080000000 : 33'($signed({1'b0, st_ff[NS].qy}));
         if (st_ff[NS].nx) qx = -qx;
         if (st_ff[NS].ny) qy = -qy;
         if (qx > 33'sh07fffffff) qx = 33'sh07fffffff;
         if (qy > 33'sh07fffffff) qy = 33'sh07fffffff;
         ex = 34'(64'sd1 <<< FRAC_BITS) + 34'(qx);
         ey = 34'(64'sd1 <<< FRAC_BITS) - 34'(qy);
         mx_ff <= 49'($signed({1'b0, scr_w})) * 49'(ex);
         my_ff <= 49'($signed({1'b0, scr_h})) * 49'(ey);
         bw_ff <= 48'($signed({1'b0, scr_w})) <<< FRAC_BITS;
         bh_ff <= 48'($signed({1'b0, scr_h})) <<< FRAC_BITS;
         front_ff <= st_ff[NS].front;
         dep_ff <= st_ff[NS].depth;
         // bounds and saturation stage
         sx = mx_ff >>> 1;
         sy = my_ff >>> 1;
         lw = bw_ff;
         lh = bh_ff;
         r_ff.depth <= dep_ff;
         r_ff.screen_x <= front_ff ? sat32((ROW_W+17)'(sx)) : '0;
         r_ff.screen_y <= front_ff ? sat32((ROW_W+17)'(sy)) : '0;
         r_ff.visible <= front_ff && sx >= 0 && sx <= 49'(lw)
            && sy >= 0 && sy <= 49'(lh);
         f2_ff <= front_ff;
         dep2_ff <= dep_ff;
      end
   end

   a_hid: assert property (@(posedge clock) disable iff (reset)
      v_ff[NS+2] && !f2_ff |-> !r_ff.visible && r_ff.screen_x == 0)
      else $error("hidden point shows on screen");
   a_dep: assert property (@(posedge clock) disable iff (reset)
      v_ff[NS+2] |-> r_ff.depth == dep2_ff)
      else $error("depth mismatch");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      v_ff[NS+2] && !out_ready |=> $stable(r_ff))
      else $error("result changed while stalled");
endmodule
